FILE: design/zero_intelligence_trade_step_top_macros.svh
// Assertion macros for the trade step block
`ifndef ZERO_INTELLIGENCE_TRADE_STEP_TOP_MACROS_SVH
`define ZERO_INTELLIGENCE_TRADE_STEP_TOP_MACROS_SVH
`ifndef SYNTH
`define ZI_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ZI_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ZI_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define ZI_ASSERT_NXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

FILE: design/zits_pkg.sv
`timescale 1ns / 1ps
package zits_pkg;
    localparam int AGENTS_DEF  = 1024;
    localparam int COUNT_W     = 11;
    localparam int PRICE_W     = 8;
    localparam int SLOT_W      = 10;
    localparam int RAND_W      = 31;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam logic [MODE_W-1:0] MODE_LOAD_BUYER  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_SELLER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRADE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AGENT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE   = 1'b1;
endpackage

FILE: design/zero_intelligence_trade_step_top.sv
`timescale 1ns / 1ps
// Channel    | Ports                                              | Timing
// command    | start, busy, mode, agent_index, agent_value, rand_* | start when !busy
// result     | done, traded, buyer_slot .. deal_price             | one-cycle strobe
// config     | cfg_we, cfg_index, cfg_data                        | write when idle
// A load runs through S_LOAD and S_OUT to done. A trade runs its modulo
// draws on the shared restoring divider, one quotient bit per cycle: buyer, seller,
// bid and ask, then the deal price only when it settles.
// Agent tables sit in two synchronous RAMs with registered reads.
// Reset restores control state, done, the divider step and the config registers only;
// tables stay undefined until loaded. The receiver cannot stall: done is high for a single cycle.
`include "zero_intelligence_trade_step_top_macros.svh"
module zero_intelligence_trade_step_top #(
    parameter int AGENTS = zits_pkg::AGENTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [zits_pkg::MODE_W-1:0]       mode,
    input  logic [zits_pkg::SLOT_W-1:0]       agent_index,
    input  logic [zits_pkg::PRICE_W-1:0]      agent_value,
    input  logic [zits_pkg::RAND_W-1:0]       rand_buyer,
    input  logic [zits_pkg::RAND_W-1:0]       rand_bid,
    input  logic [zits_pkg::RAND_W-1:0]       rand_seller,
    input  logic [zits_pkg::RAND_W-1:0]       rand_ask,
    input  logic [zits_pkg::RAND_W-1:0]       rand_price,
    input  logic                              cfg_we,
    input  logic [zits_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [zits_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              done,
    output logic                              traded,
    output logic [zits_pkg::SLOT_W-1:0]       buyer_slot,
    output logic [zits_pkg::SLOT_W-1:0]       seller_slot,
    output logic [zits_pkg::PRICE_W-1:0]      bid_price,
    output logic [zits_pkg::PRICE_W-1:0]      ask_price,
    output logic [zits_pkg::PRICE_W-1:0]      deal_price
);
    import zits_pkg::*;

    localparam int IDXW   = (AGENTS > 1) ? $clog2(AGENTS) : 1;
    localparam int CNTW   = $clog2(AGENTS + 1);
    localparam int DIVW   = (CNTW > PRICE_W) ? CNTW : PRICE_W;
    localparam int STEPW  = $clog2(RAND_W + 1);
    localparam int ENTW   = 2 * PRICE_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DIV_B, S_DIV_S, S_RD, S_RDW, S_DIV_BID, S_DIV_ASK,
        S_CHK, S_DIV_DEAL, S_WB, S_OUT
    } state_t;

    state_t state_reg;
    logic [COUNT_W-1:0] count_cfg_reg;
    logic [PRICE_W-1:0] max_cfg_reg;

    logic [ENTW-1:0] buyer_mem  [AGENTS];
    logic [ENTW-1:0] seller_mem [AGENTS];
    logic [ENTW-1:0] buyer_q_reg, seller_q_reg;

    logic [MODE_W-1:0]  mode_reg;
    logic [SLOT_W-1:0]  index_reg;
    logic [PRICE_W-1:0] value_reg;
    logic [RAND_W-1:0]  r_bid_reg, r_seller_reg, r_ask_reg, r_price_reg;

    logic [IDXW-1:0]    b_reg, s_reg;
    logic [PRICE_W-1:0] bid_reg, ask_reg, deal_reg;
    logic               ok_reg;

    // shared restoring divider, remainder only
    logic [RAND_W-1:0]  dq_reg;
    logic [DIVW:0]      drem_reg;
    logic [DIVW-1:0]    dden_reg;
    logic [STEPW-1:0]   dstep_reg;
    logic [DIVW:0]      dshift, dsub;
    logic               dlast;

    logic [CNTW-1:0]    n_eff;
    logic [PRICE_W-1:0] m_eff, val_cl;
    logic [PRICE_W-1:0] bv, sv, span;
    logic [PRICE_W:0]   bid_w;

    always_comb
    begin
        if (count_cfg_reg == '0)
            n_eff = CNTW'(1);
        else if ({{(32-COUNT_W){1'b0}}, count_cfg_reg} > 32'(AGENTS))
            n_eff = CNTW'(AGENTS);
        else
            n_eff = CNTW'(count_cfg_reg);
        m_eff  = (max_cfg_reg == '0) ? PRICE_W'(1) : max_cfg_reg;
        val_cl = (value_reg == '0) ? PRICE_W'(1) : value_reg;
        if (val_cl > m_eff)
            val_cl = m_eff;
        bv   = buyer_q_reg[ENTW-1 -: PRICE_W];
        sv   = seller_q_reg[ENTW-1 -: PRICE_W];
        span = (sv <= m_eff) ? PRICE_W'(m_eff - sv + PRICE_W'(1)) : PRICE_W'(1);
        dshift = {drem_reg[DIVW-1:0], dq_reg[RAND_W-1]};
        dsub   = dshift - {1'b0, dden_reg};
        dlast  = (dstep_reg == STEPW'(RAND_W - 1));
        bid_w  = {1'b0, bid_reg} - {1'b0, ask_reg} + (PRICE_W+1)'(1);
    end

    logic [DIVW:0] drem_next;
    assign drem_next = dsub[DIVW] ? dshift : dsub;
    logic [PRICE_W-1:0] rem8;
    assign rem8 = drem_next[PRICE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_cfg_reg <= COUNT_W'(1024);
            max_cfg_reg   <= PRICE_W'(30);
            done          <= 1'b0;
            dstep_reg     <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_AGENT_COUNT: count_cfg_reg <= cfg_data[COUNT_W-1:0];
                    REG_MAX_VALUE:   max_cfg_reg   <= cfg_data[PRICE_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_DIV_B || state_reg == S_DIV_S || state_reg == S_DIV_BID ||
                state_reg == S_DIV_ASK || state_reg == S_DIV_DEAL)
            begin
                dq_reg    <= {dq_reg[RAND_W-2:0], 1'b0};
                drem_reg  <= drem_next;
                dstep_reg <= dlast ? '0 : dstep_reg + STEPW'(1);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg     <= mode;
                        index_reg    <= agent_index;
                        value_reg    <= agent_value;
                        r_bid_reg    <= rand_bid;
                        r_seller_reg <= rand_seller;
                        r_ask_reg    <= rand_ask;
                        r_price_reg  <= rand_price;
                        dq_reg       <= rand_buyer;
                        drem_reg     <= '0;
                        dden_reg     <= DIVW'(n_eff);
                        dstep_reg    <= '0;
                        state_reg    <= (mode == MODE_TRADE) ? S_DIV_B : S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    ok_reg    <= 1'b0;
                    b_reg     <= '0;
                    s_reg     <= '0;
                    bid_reg   <= '0;
                    ask_reg   <= '0;
                    deal_reg  <= '0;
                    state_reg <= S_OUT;
                end
                S_DIV_B:
                begin
                    if (dlast)
                    begin
                        b_reg     <= IDXW'(drem_next);
                        dq_reg    <= r_seller_reg;
                        drem_reg  <= '0;
                        state_reg <= S_DIV_S;
                    end
                end
                S_DIV_S:
                begin
                    if (dlast)
                    begin
                        s_reg     <= IDXW'(drem_next);
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                    state_reg <= S_RDW;
                S_RDW:
                begin
                    dq_reg    <= r_bid_reg;
                    drem_reg  <= '0;
                    dden_reg  <= DIVW'((bv == '0) ? PRICE_W'(1) : bv);
                    state_reg <= S_DIV_BID;
                end
                S_DIV_BID:
                begin
                    if (dlast)
                    begin
                        bid_reg   <= rem8 + PRICE_W'(1);
                        dq_reg    <= r_ask_reg;
                        drem_reg  <= '0;
                        dden_reg  <= DIVW'(span);
                        state_reg <= S_DIV_ASK;
                    end
                end
                S_DIV_ASK:
                begin
                    if (dlast)
                    begin
                        ask_reg   <= sv + rem8;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    ok_reg    <= !buyer_q_reg[PRICE_W] && seller_q_reg[PRICE_W] &&
                                 (bid_reg >= ask_reg);
                    deal_reg  <= '0;
                    dq_reg    <= r_price_reg;
                    drem_reg  <= '0;
                    dden_reg  <= DIVW'(bid_w);
                    state_reg <= (!buyer_q_reg[PRICE_W] && seller_q_reg[PRICE_W] &&
                                  (bid_reg >= ask_reg)) ? S_DIV_DEAL : S_OUT;
                end
                S_DIV_DEAL:
                begin
                    if (dlast)
                    begin
                        deal_reg  <= ask_reg + rem8;
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // tables: {value, holds, price}
    logic load_buyer_we, load_seller_we, idx_ok;
    assign idx_ok = ({{(32-SLOT_W){1'b0}}, index_reg} < 32'(AGENTS));
    assign load_buyer_we  = (state_reg == S_LOAD) && (mode_reg == MODE_LOAD_BUYER) && idx_ok;
    assign load_seller_we = (state_reg == S_LOAD) && (mode_reg == MODE_LOAD_SELLER) && idx_ok;

    always_ff @(posedge clk)
    begin
        if (load_buyer_we)
            buyer_mem[IDXW'(index_reg)] <= {val_cl, 1'b0, buyer_q_reg[PRICE_W-1:0]};
        else if (state_reg == S_WB)
            buyer_mem[b_reg] <= {bv, 1'b1, deal_reg};
        if (load_seller_we)
            seller_mem[IDXW'(index_reg)] <= {val_cl, 1'b1, seller_q_reg[PRICE_W-1:0]};
        else if (state_reg == S_WB)
            seller_mem[s_reg] <= {sv, 1'b0, deal_reg};
        if (state_reg == S_RD)
        begin
            buyer_q_reg  <= buyer_mem[b_reg];
            seller_q_reg <= seller_mem[s_reg];
        end
        else if (state_reg == S_IDLE)
        begin
            buyer_q_reg  <= buyer_mem[IDXW'(agent_index)];
            seller_q_reg <= seller_mem[IDXW'(agent_index)];
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign traded      = ok_reg;
    assign buyer_slot  = SLOT_W'(b_reg);
    assign seller_slot = SLOT_W'(s_reg);
    assign bid_price   = bid_reg;
    assign ask_price   = ask_reg;
    assign deal_price  = deal_reg;

    `ZI_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ZI_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `ZI_ASSERT_IMP(a_deal_zero, clk, rst_n, done && !traded, deal_price == '0)
    `ZI_ASSERT_IMP(a_deal_range, clk, rst_n, done && traded,
        (deal_price >= ask_price) && (deal_price <= bid_price))
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import zits_pkg::*;

    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int FILL_SLOTS     = 64;
    localparam int PHASE_ITEMS    = 110;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [SLOT_W-1:0]  slot;
        logic [PRICE_W-1:0] value;
        logic [RAND_W-1:0]  r_buyer;
        logic [RAND_W-1:0]  r_bid;
        logic [RAND_W-1:0]  r_seller;
        logic [RAND_W-1:0]  r_ask;
        logic [RAND_W-1:0]  r_price;
    } command_t;

    typedef struct {
        logic               traded;
        logic [SLOT_W-1:0]  buyer;
        logic [SLOT_W-1:0]  seller;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [PRICE_W-1:0] deal;
    } outcome_t;

    class market_book;
        logic [COUNT_W-1:0] count_reg;
        logic [PRICE_W-1:0] max_reg;
        logic [PRICE_W-1:0] b_value [AGENTS_DEF];
        logic               b_holds [AGENTS_DEF];
        logic [PRICE_W-1:0] s_value [AGENTS_DEF];
        logic               s_holds [AGENTS_DEF];
        outcome_t           pending [$];
        int                 errors;
        int                 trades;
        int                 outcomes;

        function new();
            count_reg = 11'd1024;
            max_reg   = 8'd30;
            errors    = 0;
            trades    = 0;
            outcomes  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_AGENT_COUNT)
                count_reg = data;
            else
                max_reg = data[PRICE_W-1:0];
        endfunction

        function int unsigned agents_in_use();
            int unsigned n;
            n = 32'(count_reg);
            if (n < 1) n = 1;
            if (n > AGENTS_DEF) n = AGENTS_DEF;
            return n;
        endfunction

        function void note_command(command_t c);
            outcome_t    o;
            int unsigned m, v, n, b, s, bv, sv, bid, ask, span, deal;
            o = '{default: '0};
            m = (max_reg == 0) ? 1 : 32'(max_reg);
            if (c.mode == MODE_LOAD_BUYER || c.mode == MODE_LOAD_SELLER) begin
                v = 32'(c.value);
                if (v < 1) v = 1;
                if (v > m) v = m;
                if (c.mode == MODE_LOAD_BUYER) begin
                    b_value[c.slot] = PRICE_W'(v);
                    b_holds[c.slot] = 1'b0;
                end
                else begin
                    s_value[c.slot] = PRICE_W'(v);
                    s_holds[c.slot] = 1'b1;
                end
            end
            else if (c.mode == MODE_TRADE) begin
                n    = agents_in_use();
                b    = 32'(c.r_buyer) % n;
                s    = 32'(c.r_seller) % n;
                bv   = 32'(b_value[b]);
                sv   = 32'(s_value[s]);
                bid  = 32'(c.r_bid) % ((bv == 0) ? 1 : bv) + 1;
                span = (sv <= m) ? (m - sv + 1) : 1;
                ask  = sv + 32'(c.r_ask) % span;
                deal = 0;
                if (!b_holds[b] && s_holds[s] && bid >= ask) begin
                    deal = ask + 32'(c.r_price) % (bid - ask + 1);
                    b_holds[b] = 1'b1;
                    s_holds[s] = 1'b0;
                    o.traded = 1'b1;
                    trades++;
                end
                o.buyer  = SLOT_W'(b);
                o.seller = SLOT_W'(s);
                o.bid    = PRICE_W'(bid);
                o.ask    = PRICE_W'(ask);
                o.deal   = PRICE_W'(deal);
            end
            pending.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t e;
            outcomes++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result traded=%0d", $time, got.traded);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.traded !== e.traded) begin
                $display("%0t: traded exp %0d got %0d", $time, e.traded, got.traded);
                errors++;
            end
            if (got.buyer !== e.buyer) begin
                $display("%0t: buyer_slot exp %0d got %0d", $time, e.buyer, got.buyer);
                errors++;
            end
            if (got.seller !== e.seller) begin
                $display("%0t: seller_slot exp %0d got %0d", $time, e.seller, got.seller);
                errors++;
            end
            if (got.bid !== e.bid) begin
                $display("%0t: bid_price exp %0d got %0d", $time, e.bid, got.bid);
                errors++;
            end
            if (got.ask !== e.ask) begin
                $display("%0t: ask_price exp %0d got %0d", $time, e.ask, got.ask);
                errors++;
            end
            if (got.deal !== e.deal) begin
                $display("%0t: deal_price exp %0d got %0d", $time, e.deal, got.deal);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [MODE_W-1:0]     mode;
    logic [SLOT_W-1:0]     agent_index;
    logic [PRICE_W-1:0]    agent_value;
    logic [RAND_W-1:0]     rand_buyer;
    logic [RAND_W-1:0]     rand_bid;
    logic [RAND_W-1:0]     rand_seller;
    logic [RAND_W-1:0]     rand_ask;
    logic [RAND_W-1:0]     rand_price;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic                  traded;
    logic [SLOT_W-1:0]     buyer_slot;
    logic [SLOT_W-1:0]     seller_slot;
    logic [PRICE_W-1:0]    bid_price;
    logic [PRICE_W-1:0]    ask_price;
    logic [PRICE_W-1:0]    deal_price;

    market_book book;
    int         cycles;
    int         sent;

    zero_intelligence_trade_step_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .agent_index (agent_index),
        .agent_value (agent_value),
        .rand_buyer  (rand_buyer),
        .rand_bid    (rand_bid),
        .rand_seller (rand_seller),
        .rand_ask    (rand_ask),
        .rand_price  (rand_price),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .traded      (traded),
        .buyer_slot  (buyer_slot),
        .seller_slot (seller_slot),
        .bid_price   (bid_price),
        .ask_price   (ask_price),
        .deal_price  (deal_price)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("%0t: timeout", $time);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        outcome_t r;
        if (rst_n && done) begin
            r.traded = traded;
            r.buyer  = buyer_slot;
            r.seller = seller_slot;
            r.bid    = bid_price;
            r.ask    = ask_price;
            r.deal   = deal_price;
            book.check_result(r);
        end
    end

    // call at a rising edge; start stays high on return
    task automatic send(command_t c);
        start       <= 1'b1;
        mode        <= c.mode;
        agent_index <= c.slot;
        agent_value <= c.value;
        rand_buyer  <= c.r_buyer;
        rand_bid    <= c.r_bid;
        rand_seller <= c.r_seller;
        rand_ask    <= c.r_ask;
        rand_price  <= c.r_price;
        do
            @(posedge clk);
        while (busy);
        book.note_command(c);
        sent++;
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        book.write_reg(idx, data);
    endtask

    function automatic logic [RAND_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return RAND_W'($urandom());
        endcase
    endfunction

    // keep the draw on a loaded slot while leaving the upper bits random
    function automatic logic [RAND_W-1:0] slot_word(int unsigned n);
        logic [RAND_W-1:0] r;
        r = rand_word();
        if (n > FILL_SLOTS)
            r = r - RAND_W'(32'(r) % n) + RAND_W'(32'(r) % FILL_SLOTS);
        return r;
    endfunction

    function automatic command_t random_command();
        command_t    c;
        int unsigned n;
        n = book.agents_in_use();
        c.r_buyer  = slot_word(n);
        c.r_bid    = rand_word();
        c.r_seller = slot_word(n);
        c.r_ask    = rand_word();
        c.r_price  = rand_word();
        c.value    = PRICE_W'($urandom_range(0, 255));
        c.slot     = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 1023))
                                                 : SLOT_W'($urandom_range(0, n - 1));
        case ($urandom_range(0, 19))
            0:             c.mode = MODE_IDLE;
            1, 2, 3, 4:    c.mode = MODE_LOAD_BUYER;
            5, 6, 7, 8:    c.mode = MODE_LOAD_SELLER;
            default:       c.mode = MODE_TRADE;
        endcase
        return c;
    endfunction

    function automatic command_t make_cmd(logic [MODE_W-1:0] md, int slot, int value,
                                          logic [RAND_W-1:0] r);
        command_t c;
        c.mode     = md;
        c.slot     = SLOT_W'(slot);
        c.value    = PRICE_W'(value);
        c.r_buyer  = r;
        c.r_bid    = r;
        c.r_seller = r;
        c.r_ask    = r;
        c.r_price  = r;
        return c;
    endfunction

    initial
    begin
        int counts [7];
        int maxes  [7];
        int k;
        command_t c;
        book        = new();
        cycles      = 0;
        sent        = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_LOAD_BUYER;
        agent_index = '0;
        agent_value = '0;
        rand_buyer  = '0;
        rand_bid    = '0;
        rand_seller = '0;
        rand_ask    = '0;
        rand_price  = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_AGENT_COUNT;
        cfg_data    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the low slots; trades at wide counts are steered onto them
        write_reg(REG_MAX_VALUE, 11'd255);
        for (int i = 0; i < FILL_SLOTS; i++) begin
            send(make_cmd(MODE_LOAD_BUYER, i, $urandom_range(0, 255), '0));
            send(make_cmd(MODE_LOAD_SELLER, i, $urandom_range(0, 255), '0));
        end

        write_reg(REG_MAX_VALUE, 11'd30);
        send(make_cmd(MODE_LOAD_BUYER, 0, 0, '1));
        send(make_cmd(MODE_LOAD_BUYER, 1023, 255, '0));
        send(make_cmd(MODE_LOAD_SELLER, 0, 0, '1));
        send(make_cmd(MODE_LOAD_SELLER, 1023, 255, '0));
        send(make_cmd(MODE_IDLE, 1023, 255, '1));
        send(make_cmd(MODE_IDLE, 0, 0, '0));
        send(make_cmd(MODE_TRADE, 0, 0, '0));
        send(make_cmd(MODE_TRADE, 1023, 255, '1));
        c = make_cmd(MODE_TRADE, 0, 0, '0);
        c.r_buyer  = 31'd1023;
        c.r_seller = 31'd1023;
        send(c);
        send(make_cmd(MODE_LOAD_BUYER, 5, 30, '0));
        send(make_cmd(MODE_LOAD_SELLER, 5, 1, '0));
        c = make_cmd(MODE_TRADE, 0, 0, '1);
        c.r_buyer  = 31'd5;
        c.r_seller = 31'd5;
        send(c);
        send(c);

        counts = '{2, 0, 2047, 1024, 7, 3, 16};
        maxes  = '{1, 255, 255, 100, 1, 0, 30};
        for (int p = 0; p < 7; p++) begin
            write_reg(REG_AGENT_COUNT, CFG_DATA_W'(counts[p]));
            write_reg(REG_MAX_VALUE, CFG_DATA_W'(maxes[p]));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == 60)
                    drain();
                else if (p < 6 && $urandom_range(0, 3) == 0)
                    pause($urandom_range(1, 10));
                send(random_command());
            end
        end

        drain();
        repeat (70) @(posedge clk);
        $display("%0d commands driven over 7 register settings, %0d results checked",
                 sent, book.outcomes);
        $display("%0d trades settled, %0d mismatches", book.trades, book.errors);
        if (book.errors == 0 && book.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
